>>> hdl/jfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfd_pkg
// Shared constants and types of the JPEG frame delimiter: marker bytes,
// frame length limit and the command item passed from front to back.
// ----------------------------------------------------------------------------
package jfd_pkg;

    // Marker bytes
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_D8 = 8'hD8;
    localparam logic [7:0] BYTE_D9 = 8'hD9;

    // Frame length limit and counter width
    localparam int unsigned LEN_W = 21;
    localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 21'd1048576;

    // Command queue depth (power of two)
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // Command kinds from front to back
    localparam logic [1:0] CMD_START = 2'd0;  // emit FF (start) then D8
    localparam logic [1:0] CMD_DATA  = 2'd1;  // forward one frame byte
    localparam logic [1:0] CMD_END   = 2'd2;  // forward closing D9 with length
    localparam logic [1:0] CMD_ABORT = 2'd3;  // frame scrapped

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

>>> hdl/jpeg_frame_delimiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_frame_delimiter
// Finds FF D8 ... FF D9 framed JPEG images in a byte stream and forwards
// the frame bytes with start, end, length and abort marks.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while the command queue is not full. Each
// byte passes the marker matcher in the cycle it is accepted and leaves at
// most one command in a four-entry queue; the result stage behind it delivers
// one item per cycle while the output is popped, and a frame start yields two
// items (FF and D8) from one command, which the queue absorbs while the input
// keeps flowing. An item passes the command queue and then the output register
// before it appears on the output. After reset the block is ready at once.
// ----------------------------------------------------------------------------
module jpeg_frame_delimiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  o_data_byte,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic        o_frame_abort,
    output logic [20:0] o_frame_length,
    output logic        o_run_last
);

    logic          accept;
    logic          cmd_push, cmd_pop, cmd_empty;
    jfd_pkg::t_cmd cmd_in, cmd_out;

    assign accept = push && !full;

    // Marker matcher and frame counter
    jfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // Command queue
    jfd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    // Result generator
    jfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_out),
        .i_cmd_empty    (cmd_empty),
        .o_cmd_pop      (cmd_pop),
        .pop            (pop),
        .empty          (empty),
        .o_data_byte    (o_data_byte),
        .o_frame_start  (o_frame_start),
        .o_frame_end    (o_frame_end),
        .o_frame_abort  (o_frame_abort),
        .o_frame_length (o_frame_length),
        .o_run_last     (o_run_last)
    );

endmodule

>>> hdl/jfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfd_front
// Marker matcher: tracks FF D8 / FF D9, counts frame bytes and turns each
// accepted input byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module jfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    output logic          o_cmd_push,
    output jfd_pkg::t_cmd o_cmd
);

    // Match phase codes
    localparam logic [1:0] PH_WAIT_FF_START = 2'd0;
    localparam logic [1:0] PH_WAIT_D8       = 2'd1;
    localparam logic [1:0] PH_WAIT_FF_END   = 2'd2;
    localparam logic [1:0] PH_WAIT_D9       = 2'd3;

    logic [1:0]                r_phase, n_phase;
    logic [jfd_pkg::LEN_W-1:0] r_count, n_count;
    logic                      room;
    logic [jfd_pkg::LEN_W-1:0] count_inc;

    assign room      = r_count < jfd_pkg::MAX_FRAME_BYTES;
    assign count_inc = r_count + 1'b1;

    // Next state and command
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        o_cmd_push   = 1'b0;
        o_cmd.kind   = jfd_pkg::CMD_DATA;
        o_cmd.data   = i_in_byte;
        o_cmd.len    = '0;
        unique case (r_phase)
            PH_WAIT_FF_START: begin
                if (i_in_byte == jfd_pkg::BYTE_FF) begin
                    n_phase = PH_WAIT_D8;
                end
            end
            PH_WAIT_D8: begin
                if (i_in_byte == jfd_pkg::BYTE_D8) begin
                    n_phase    = PH_WAIT_FF_END;
                    n_count    = jfd_pkg::LEN_W'(2);
                    o_cmd_push = 1'b1;
                    o_cmd.kind = jfd_pkg::CMD_START;
                end else begin
                    n_phase = PH_WAIT_FF_START;
                end
            end
            PH_WAIT_FF_END: begin
                o_cmd_push = 1'b1;
                if (!room) begin
                    n_phase    = PH_WAIT_FF_START;
                    o_cmd.kind = jfd_pkg::CMD_ABORT;
                    o_cmd.data = '0;
                end else begin
                    if (i_in_byte == jfd_pkg::BYTE_FF) begin
                        n_phase = PH_WAIT_D9;
                    end
                    n_count = count_inc;
                end
            end
            PH_WAIT_D9: begin
                o_cmd_push = 1'b1;
                if (!room) begin
                    n_phase    = PH_WAIT_FF_START;
                    o_cmd.kind = jfd_pkg::CMD_ABORT;
                    o_cmd.data = '0;
                end else begin
                    n_count = count_inc;
                    if (i_in_byte == jfd_pkg::BYTE_D9) begin
                        n_phase    = PH_WAIT_FF_START;
                        o_cmd.kind = jfd_pkg::CMD_END;
                        o_cmd.len  = count_inc;
                    end else begin
                        n_phase = PH_WAIT_FF_END;
                    end
                end
            end
            default: begin
                n_phase = PH_WAIT_FF_START;
            end
        endcase
        if (!i_accept) begin
            n_phase    = r_phase;
            n_count    = r_count;
            o_cmd_push = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_FF_START;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/jfd_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfd_cmd_fifo
// Short command queue between matcher and result generator.
// ----------------------------------------------------------------------------
module jfd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jfd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output jfd_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    jfd_pkg::t_cmd               r_mem [jfd_pkg::CMDQ_DEPTH];
    logic [jfd_pkg::CMDQ_AW-1:0] r_wr_ptr;
    logic [jfd_pkg::CMDQ_AW-1:0] r_rd_ptr;
    logic [jfd_pkg::CMDQ_AW:0]   r_level;
    logic                        do_push, do_pop;

    assign o_full  = r_level == (jfd_pkg::CMDQ_AW+1)'(jfd_pkg::CMDQ_DEPTH);
    assign o_empty = r_level == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

>>> hdl/jfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfd_back
// Result generator: expands queued commands into result items and holds
// the oldest one in an output register until it is popped.
// ----------------------------------------------------------------------------
module jfd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  jfd_pkg::t_cmd             i_cmd,
    input  logic                      i_cmd_empty,
    output logic                      o_cmd_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [7:0]                o_data_byte,
    output logic                      o_frame_start,
    output logic                      o_frame_end,
    output logic                      o_frame_abort,
    output logic [jfd_pkg::LEN_W-1:0] o_frame_length,
    output logic                      o_run_last
);

    logic                      r_valid;
    logic                      r_half;   // D8 of a frame start still owed
    logic [7:0]                r_data;
    logic                      r_start, r_end, r_abort, r_last;
    logic [jfd_pkg::LEN_W-1:0] r_len;
    logic [7:0]                n_data;
    logic                      n_start, n_end, n_abort, n_last;
    logic [jfd_pkg::LEN_W-1:0] n_len;
    logic                      load;

    assign load      = !r_valid || pop;
    assign o_cmd_pop = load && !r_half && !i_cmd_empty;

    // Control: valid flag and pending second half of a start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            if (r_half) begin
                r_valid <= 1'b1;
                r_half  <= 1'b0;
            end else if (!i_cmd_empty) begin
                r_valid <= 1'b1;
                r_half  <= i_cmd.kind == jfd_pkg::CMD_START;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Next result payload
    always_comb begin
        n_data  = i_cmd.data;
        n_start = 1'b0;
        n_end   = 1'b0;
        n_abort = 1'b0;
        n_len   = '0;
        n_last  = 1'b1;
        if (r_half) begin
            n_data = jfd_pkg::BYTE_D8;
        end else if (!i_cmd_empty) begin
            unique case (i_cmd.kind)
                jfd_pkg::CMD_START: begin
                    n_data  = jfd_pkg::BYTE_FF;
                    n_start = 1'b1;
                    n_last  = 1'b0;
                end
                jfd_pkg::CMD_DATA: begin
                end
                jfd_pkg::CMD_END: begin
                    n_end = 1'b1;
                    n_len = i_cmd.len;
                end
                jfd_pkg::CMD_ABORT: begin
                    n_data  = '0;
                    n_abort = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data  <= n_data;
            r_start <= n_start;
            r_end   <= n_end;
            r_abort <= n_abort;
            r_len   <= n_len;
            r_last  <= n_last;
        end
    end

    assign empty          = !r_valid;
    assign o_data_byte    = r_data;
    assign o_frame_start  = r_start;
    assign o_frame_end    = r_end;
    assign o_frame_abort  = r_abort;
    assign o_frame_length = r_len;
    assign o_run_last     = r_last;

endmodule

>>> bench/jfd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfd_frame_checker
// Watches the byte input and the result queue of the JPEG frame delimiter,
// tracks the marker matching and frame length of the stream on its own, and
// compares every popped item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module jfd_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_pop,
    input  logic        i_empty,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_frame_end,
    input  logic        i_frame_abort,
    input  logic [20:0] i_frame_length,
    input  logic        i_run_last,
    output int          o_mismatches,
    output int          o_items_due
);

    // Marker matching phase of the stream
    typedef enum logic [1:0] {
        WAIT_SOI_FF,    // outside a frame, looking for FF
        WAIT_SOI_D8,    // FF seen, D8 opens a frame
        IN_FRAME,       // inside a frame, looking for FF
        WAIT_EOI_D9     // inside a frame after FF, D9 closes it
    } t_delim_phase;

    typedef struct packed {
        logic [7:0]                data;
        logic                      sof;
        logic                      eof;
        logic                      scrap;
        logic [jfd_pkg::LEN_W-1:0] length;
        logic                      last;
    } t_frame_item;

    t_delim_phase              phase;
    logic [jfd_pkg::LEN_W-1:0] frame_count;
    t_frame_item               frame_items_due[$];
    int                        mismatches = 0;

    // Advance the matcher by one stream byte and queue the items it yields
    task automatic track_stream_byte(input logic [7:0] b);
        t_frame_item it;
        logic        room;
        room = (frame_count < jfd_pkg::MAX_FRAME_BYTES);
        it   = '0;
        case (phase)
            WAIT_SOI_FF: begin
                if (b == jfd_pkg::BYTE_FF) phase = WAIT_SOI_D8;
            end
            WAIT_SOI_D8: begin
                if (b == jfd_pkg::BYTE_D8) begin
                    phase       = IN_FRAME;
                    frame_count = jfd_pkg::LEN_W'(2);
                    it.data     = jfd_pkg::BYTE_FF;
                    it.sof      = 1'b1;
                    frame_items_due.push_back(it);
                    it          = '0;
                    it.data     = jfd_pkg::BYTE_D8;
                    it.last     = 1'b1;
                    frame_items_due.push_back(it);
                end else begin
                    phase = WAIT_SOI_FF;
                end
            end
            default: begin
                if (!room) begin
                    // frame too long: scrap it and hunt for the next start
                    phase    = WAIT_SOI_FF;
                    it.scrap = 1'b1;
                    it.last  = 1'b1;
                end else begin
                    frame_count = frame_count + 1'b1;
                    it.data     = b;
                    it.last     = 1'b1;
                    if (phase == WAIT_EOI_D9 && b == jfd_pkg::BYTE_D9) begin
                        it.eof    = 1'b1;
                        it.length = frame_count;
                        phase     = WAIT_SOI_FF;
                    end else if (phase == IN_FRAME && b == jfd_pkg::BYTE_FF) begin
                        phase = WAIT_EOI_D9;
                    end else begin
                        // a second FF also lands here and restarts the match
                        phase = IN_FRAME;
                    end
                end
                frame_items_due.push_back(it);
            end
        endcase
    endtask

    task automatic check_field(input string name,
                               input logic [jfd_pkg::LEN_W-1:0] want,
                               input logic [jfd_pkg::LEN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare popped items first: nothing accepted at this edge can be among them
    always @(posedge i_clk) begin : watch
        t_frame_item want;
        if (!i_rst_n) begin
            phase       = WAIT_SOI_FF;
            frame_count = '0;
            frame_items_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (frame_items_due.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual data 0x%0h",
                             $time, i_data_byte);
                    mismatches++;
                end else begin
                    want = frame_items_due.pop_front();
                    check_field("data_byte", jfd_pkg::LEN_W'(want.data),
                                jfd_pkg::LEN_W'(i_data_byte));
                    check_field("frame_start", jfd_pkg::LEN_W'(want.sof),
                                jfd_pkg::LEN_W'(i_frame_start));
                    check_field("frame_end", jfd_pkg::LEN_W'(want.eof),
                                jfd_pkg::LEN_W'(i_frame_end));
                    check_field("frame_abort", jfd_pkg::LEN_W'(want.scrap),
                                jfd_pkg::LEN_W'(i_frame_abort));
                    check_field("frame_length", want.length, i_frame_length);
                    check_field("run_last", jfd_pkg::LEN_W'(want.last),
                                jfd_pkg::LEN_W'(i_run_last));
                end
            end
            if (i_push && !i_full) track_stream_byte(i_in_byte);
        end
        o_items_due  = frame_items_due.size();
        o_mismatches = mismatches;
    end

endmodule

>>> bench/jpeg_frame_delimiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_frame_delimiter_tb
// Feeds the frame delimiter a directed byte stream covering the marker
// corner cases, then random frames, broken markers and noise with random
// gaps and back-pressure, and finally a few frames with no idling.
// Checking is done by jfd_frame_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module jpeg_frame_delimiter_tb;

    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES  = 48;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        pop;
    logic        empty;
    logic [7:0]  o_data_byte;
    logic        o_frame_start;
    logic        o_frame_end;
    logic        o_frame_abort;
    logic [20:0] o_frame_length;
    logic        o_run_last;

    int   mismatches;
    int   items_due;
    int   bytes_sent = 0;
    logic tx_idle_en = 1'b0;
    logic rx_idle_en = 1'b0;
    logic hold_req   = 1'b0;

    jpeg_frame_delimiter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .pop            (pop),
        .empty          (empty),
        .o_data_byte    (o_data_byte),
        .o_frame_start  (o_frame_start),
        .o_frame_end    (o_frame_end),
        .o_frame_abort  (o_frame_abort),
        .o_frame_length (o_frame_length),
        .o_run_last     (o_run_last)
    );

    jfd_frame_checker u_frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_in_byte      (i_in_byte),
        .i_pop          (pop),
        .i_empty        (empty),
        .i_data_byte    (o_data_byte),
        .i_frame_start  (o_frame_start),
        .i_frame_end    (o_frame_end),
        .i_frame_abort  (o_frame_abort),
        .i_frame_length (o_frame_length),
        .i_run_last     (o_run_last),
        .o_mismatches   (mismatches),
        .o_items_due    (items_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    // Result side: random short stalls, plus one long hold-off on request
    initial begin : result_side
        int   idle_left;
        logic hold_taken;
        idle_left  = 0;
        hold_taken = 1'b0;
        pop        = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (idle_left > 0) begin
                idle_left--;
                pop <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                idle_left  = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                idle_left = $urandom_range(0, 2);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one byte, possibly after a short gap, and wait until it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        @(negedge i_clk);
        push      <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    // Frame body byte, biased toward the marker values
    function automatic logic [7:0] pick_frame_byte();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0, 1:    return jfd_pkg::BYTE_FF;
            2:       return jfd_pkg::BYTE_D8;
            3:       return jfd_pkg::BYTE_D9;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int body_len, input logic closed);
        send_byte(jfd_pkg::BYTE_FF);
        send_byte(jfd_pkg::BYTE_D8);
        repeat (body_len) send_byte(pick_frame_byte());
        if (closed) begin
            send_byte(jfd_pkg::BYTE_FF);
            send_byte(jfd_pkg::BYTE_D9);
        end
    endtask

    // Stop offering and wait until every expected item has come out
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        wait (items_due == 0);
    endtask

    initial begin : stimulus
        logic [7:0] corner_bytes [22];
        int         kind;
        int         next_drain;
        logic       hold_done;

        corner_bytes = '{
            8'h00, jfd_pkg::BYTE_D8, jfd_pkg::BYTE_FF, 8'h55,
            jfd_pkg::BYTE_FF, jfd_pkg::BYTE_FF, jfd_pkg::BYTE_D8, jfd_pkg::BYTE_D9,
            jfd_pkg::BYTE_FF, jfd_pkg::BYTE_D8, 8'h00, jfd_pkg::BYTE_FF,
            jfd_pkg::BYTE_FF, jfd_pkg::BYTE_D9, 8'h7F, 8'h80,
            jfd_pkg::BYTE_FF, jfd_pkg::BYTE_D9,
            jfd_pkg::BYTE_FF, jfd_pkg::BYTE_D8, jfd_pkg::BYTE_FF, jfd_pkg::BYTE_D9
        };
        push       = 1'b0;
        i_in_byte  = 8'h00;
        i_rst_n    = 1'b0;
        next_drain = 250;
        hold_done  = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stray bytes, FF FF D8, FF FF D9 inside a frame, minimal frame
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        foreach (corner_bytes[k]) send_byte(corner_bytes[k]);
        wait_drained();

        // Random frames with noise and broken markers in between
        while (bytes_sent < RANDOM_ITEMS) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if (!hold_done && bytes_sent >= 600) begin
                // output stalled for long while bytes keep coming: queue fills
                hold_done  = 1'b1;
                tx_idle_en = 1'b0;
                hold_req   = 1'b1;
                send_frame(30, 1'b1);
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3, 4, 5: send_frame($urandom_range(0, 12), 1'b1);
                6:                send_frame($urandom_range(0, 8), 1'b0);
                7:                repeat ($urandom_range(1, 5))
                                      send_byte(8'($urandom_range(0, 255)));
                8: begin
                    send_byte(jfd_pkg::BYTE_FF);
                    send_byte(jfd_pkg::BYTE_FF);
                    send_byte(jfd_pkg::BYTE_D8);
                end
                default: begin
                    send_byte(jfd_pkg::BYTE_FF);
                    send_byte(8'($urandom_range(0, 255)));
                end
            endcase
            if (bytes_sent >= next_drain) begin
                wait_drained();
                next_drain += 250;
            end
        end
        wait_drained();

        // Last part, no idling: back-to-back frames
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_frame(3, 1'b1);
        send_frame(5, 1'b1);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && items_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
